### design/ics_pkg.sv
// Shared types and constants for the inversion counting sorter.
package ics_pkg;

  // Fixed field widths of the transfer payloads
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } ics_in_t;

  typedef struct packed {
    logic [VAL_W-1:0]   sorted_value;
    logic [COUNT_W-1:0] inversion_count;
    logic               overflow;
    logic               last_out;
  } ics_out_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the new value, shift entries >= it up
    logic shift;   // move every entry one cell down toward cell 0
  } ics_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SETTLE,
    ST_DRAIN
  } ics_state_e;

endpackage

### design/inversion_counting_sorter.sv
// Top level: insertion sorting chain with inversion counter and output register.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) takes one value per
//   transfer; the item with last set ends a sequence. While a sequence is being
//   collected one transfer is taken every cycle. Each value is inserted into a
//   chain of MAX_ELEMENTS cells; all cells compare against it
//   in parallel, and the count of earlier values >= it is registered and then
//   added to the running count. Values past MAX_ELEMENTS are dropped and flagged.
//   After the last transfer, in_stall_o stays high while the chain unloads:
//   the control passes through a settle state, then cell 0 moves into the output
//   register each cycle the output register is free. The result channel
//   (out_valid_o / out_stall_i / out_data_o) holds its payload while out_stall_i
//   is high; the drain pauses. Once the final result is loaded, input is taken
//   again, even while that result still waits in the output register.
//   Reset empties the chain, clears the count, fill level and overflow flag.
module inversion_counting_sorter
  import ics_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned VALUE_BITS   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ics_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ics_out_t out_data_o
);

  localparam int unsigned FillW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned PosW   = $clog2(MAX_ELEMENTS);
  localparam int unsigned StoreW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int unsigned SumW   = ((COUNT_W > FillW) ? COUNT_W : FillW) + 1;
  localparam logic [FillW-1:0] FillMax = FillW'(MAX_ELEMENTS);

  ics_state_e state_q, state_d;

  logic [FillW-1:0]   fill_q, fill_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               dropped_q, dropped_d;
  logic [FillW-1:0]   ge_cnt_q;
  logic               ge_vld_q;
  logic               out_vld_q, out_vld_d;
  ics_out_t           out_q, out_d;

  ics_cell_ctrl_t     cell_ctrl;
  logic               accept_in, insert, out_ld;
  logic [StoreW-1:0]  new_val;
  logic [PosW-1:0]    pos;
  logic [FillW-1:0]   ge_cnt;
  logic [SumW-1:0]    count_sum;

  logic [MAX_ELEMENTS-1:0] cell_ge, cell_vld;
  logic [StoreW-1:0]       cell_dat [MAX_ELEMENTS];

  assign new_val   = StoreW'(in_data_i.value);
  assign in_stall_o = (state_q != ST_COLLECT);
  assign accept_in = in_valid_i && !in_stall_o;
  assign insert    = accept_in && (fill_q != FillMax);
  assign out_ld    = !out_vld_q || !out_stall_i;

  // Chain of compare-and-insert cells
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic             l_ge, l_vld, r_vld;
    logic [StoreW-1:0] l_dat, r_dat;
    if (i == 0) begin : g_first
      assign l_ge  = 1'b0;
      assign l_vld = 1'b0;
      assign l_dat = '0;
    end else begin : g_mid
      assign l_ge  = cell_ge[i-1];
      assign l_vld = cell_vld[i-1];
      assign l_dat = cell_dat[i-1];
    end
    if (i == MAX_ELEMENTS - 1) begin : g_last
      assign r_vld = 1'b0;
      assign r_dat = '0;
    end else begin : g_inner
      assign r_vld = cell_vld[i+1];
      assign r_dat = cell_dat[i+1];
    end
    ics_cell #(
      .WIDTH(StoreW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .new_val_i    (new_val),
      .left_ge_i    (l_ge),
      .left_valid_i (l_vld),
      .left_data_i  (l_dat),
      .right_valid_i(r_vld),
      .right_data_i (r_dat),
      .ge_o         (cell_ge[i]),
      .valid_o      (cell_vld[i]),
      .data_o       (cell_dat[i])
    );
  end

  // Insert position: index of the one cell where the ge thermometer starts
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (cell_ge[i] && (i == 0 || !cell_ge[(i == 0) ? 0 : i-1])) begin
        pos = pos | PosW'(i);
      end
    end
  end

  // Stored values >= new value: all filled cells from the insert position up
  assign ge_cnt    = fill_q - FillW'(pos);
  assign count_sum = SumW'(count_q) + SumW'(ge_cnt_q);

  // Control: collect, settle the count, drain the chain
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    dropped_d = dropped_q;
    cell_ctrl = '0;
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    count_d   = count_q;
    if (ge_vld_q) begin
      count_d = (count_sum > SumW'(COUNT_SAT)) ? COUNT_SAT : COUNT_W'(count_sum);
    end
    case (state_q)
      ST_COLLECT: begin
        cell_ctrl.insert = insert;
        if (insert) begin
          fill_d = fill_q + FillW'(1);
        end else if (accept_in) begin
          dropped_d = 1'b1;
        end
        if (accept_in && in_data_i.last) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_ld) begin
          cell_ctrl.shift       = 1'b1;
          out_vld_d             = 1'b1;
          out_d.sorted_value    = VAL_W'(cell_dat[0]);
          out_d.inversion_count = count_q;
          out_d.overflow        = dropped_q;
          out_d.last_out        = (fill_q == FillW'(1));
          fill_d                = fill_q - FillW'(1);
          if (fill_q == FillW'(1)) begin
            state_d   = ST_COLLECT;
            count_d   = '0;
            dropped_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_COLLECT;
      fill_q    <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
      ge_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      ge_vld_q  <= insert;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ge_cnt_q <= ge_cnt;
    out_q    <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### design/ics_cell.sv
// One cell of the sorting chain: holds one stored value and its valid bit.
module ics_cell
  import ics_pkg::*;
#(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ics_cell_ctrl_t   ctrl_i,
  input  logic [WIDTH-1:0] new_val_i,
  input  logic             left_ge_i,
  input  logic             left_valid_i,
  input  logic [WIDTH-1:0] left_data_i,
  input  logic             right_valid_i,
  input  logic [WIDTH-1:0] right_data_i,
  output logic             ge_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q, data_d;
  logic             valid_q, valid_d;

  // Empty cells count as "greater or equal" so the flags form a thermometer
  assign ge_o    = !valid_q || (data_q >= new_val_i);
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Insert: the first ge cell takes the new value, later ge cells take their left neighbor
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.insert && ge_o) begin
      data_d  = left_ge_i ? left_data_i : new_val_i;
      valid_d = left_ge_i ? left_valid_i : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

### design/ics_checker.sv
// Port-level assertions for the inversion counting sorter, with bind.
module ics_checker
  import ics_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input ics_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input ics_out_t out_data_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The end of a sequence blocks input for the drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last |=> in_stall_o)
    else $error("input taken right after last transfer");

  // While a non-final result is shown, the chain is still draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_out |-> in_stall_o)
    else $error("input open before sequence drained");

  // A non-final result is followed at once by the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_out |=> out_valid_o)
    else $error("gap inside sorted output");

endmodule

bind inversion_counting_sorter ics_checker u_ics_checker (.*);

### tb/sv/ics_sort_checker.sv
// Checker for the inversion counting sorter: predicts sorted output and compares transfers.
`timescale 1ns / 100ps

module ics_sort_checker
  import ics_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  ics_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  ics_out_t    out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned REPORT_MAX = 10;

  // Shadow copy of the sequence being collected
  logic [VAL_W-1:0]   seq_vals [MAX_ELEMENTS];
  logic [COUNT_W-1:0] inv_total;
  int unsigned        fill_cnt;
  logic               dropped;

  // Sorted results still owed by the block, oldest first
  ics_out_t sorted_q [$];

  // Count earlier values >= the new one; on the last element queue the sorted output
  task automatic take_element(input logic [VAL_W-1:0] v, input logic is_last);
    int unsigned      ge;
    int unsigned      sum;
    int unsigned      pos;
    logic [VAL_W-1:0] order [$];
    ics_out_t         r;
    if (fill_cnt < MAX_ELEMENTS) begin
      ge = 0;
      for (int k = 0; k < fill_cnt; k++) begin
        if (seq_vals[k] >= v) ge++;
      end
      sum = inv_total + ge;
      inv_total = (sum > COUNT_SAT) ? COUNT_SAT : sum[COUNT_W-1:0];
      seq_vals[fill_cnt] = v;
      fill_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (is_last) begin
      // insert in arrival order; a later equal value lands ahead of earlier ones
      for (int i = 0; i < fill_cnt; i++) begin
        pos = 0;
        while (pos < order.size() && order[pos] < seq_vals[i]) pos++;
        order.insert(pos, seq_vals[i]);
      end
      for (int i = 0; i < order.size(); i++) begin
        r.sorted_value    = order[i];
        r.inversion_count = inv_total;
        r.overflow        = dropped;
        r.last_out        = (i == order.size() - 1);
        sorted_q.push_back(r);
      end
      inv_total = '0;
      fill_cnt  = 0;
      dropped   = 1'b0;
    end
  endtask

  // Watch both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    ics_out_t exp_r;
    if (!rst_ni) begin
      inv_total = '0;
      fill_cnt  = 0;
      dropped   = 1'b0;
      sorted_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) take_element(in_data_i.value, in_data_i.last);
      if (out_valid_i && !out_stall_i) begin
        if (sorted_q.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("%0t: unexpected result value=%h count=%0d ovf=%b end=%b", $realtime,
                     out_data_i.sorted_value, out_data_i.inversion_count,
                     out_data_i.overflow, out_data_i.last_out);
          fail_count_o++;
        end else begin
          exp_r = sorted_q.pop_front();
          if (out_data_i !== exp_r) begin
            if (fail_count_o < REPORT_MAX)
              $display("%0t: mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                       $realtime, exp_r.sorted_value, exp_r.inversion_count, exp_r.overflow,
                       exp_r.last_out, out_data_i.sorted_value, out_data_i.inversion_count,
                       out_data_i.overflow, out_data_i.last_out);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = sorted_q.size();
  end

endmodule

### tb/sv/inversion_counting_sorter_test.sv
// Testbench top for the inversion counting sorter: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module inversion_counting_sorter_test;
  import ics_pkg::*;

  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned PHASE_ITEMS  = 85;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 20;

  // Content patterns for one sequence
  typedef enum logic [2:0] {
    SHAPE_SPREAD,
    SHAPE_FEW,
    SHAPE_SAME,
    SHAPE_RISING,
    SHAPE_FALLING
  } seq_shape_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  ics_in_t  in_data_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  ics_out_t out_data_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned phase_sent;

  wire in_xfer  = in_valid_i && !in_stall_o;
  wire out_xfer = out_valid_o && !out_stall_i;

  always #5 clk_i = ~clk_i;

  inversion_counting_sorter #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_BITS  (VAL_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  ics_sort_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Random receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // One input transfer, with random gaps ahead of it; valid stays high afterward
  task automatic send_item(input logic [VAL_W-1:0] v, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_data_i.value <= v;
    in_data_i.last  <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    phase_sent++;
  endtask

  // Hold off the sender until every queued result has been transferred
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(input seq_shape_e shape, input int unsigned idx,
                                                   input logic [VAL_W-1:0] base);
    case (shape)
      SHAPE_FEW:     return VAL_W'($urandom_range(3));
      SHAPE_SAME:    return base;
      SHAPE_RISING:  return VAL_W'(base + idx);
      SHAPE_FALLING: return VAL_W'(base - idx);
      default:       return VAL_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic send_sequence(input seq_shape_e shape, input int unsigned len);
    logic [VAL_W-1:0] base;
    base = VAL_W'($urandom_range(16'hFFFF));
    for (int unsigned i = 0; i < len; i++) send_item(pick_value(shape, i, base), i == len - 1);
  endtask

  // Random sequences: mostly short, now and then near, at or past capacity
  task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                           input seq_shape_e long_shape, input int unsigned long_len);
    seq_shape_e  shape;
    int unsigned len;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    phase_sent    = 0;
    send_sequence(long_shape, long_len);
    while (phase_sent < PHASE_ITEMS) begin
      shape = seq_shape_e'($urandom_range(SHAPE_FALLING));
      len   = ($urandom_range(11) == 0) ? $urandom_range(72, 60) : $urandom_range(12, 1);
      send_sequence(shape, len);
      if ($urandom_range(7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // No transfer on either channel for too long means the block hung
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || in_xfer || out_xfer) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 11;
    recv_idle_pct = 47;
    // Directed: single extremes, ties, descending, ascending, mixed
    send_item(16'h0000, 1'b1);
    send_item(16'hFFFF, 1'b1);
    send_item(16'h0005, 1'b0);
    send_item(16'h0005, 1'b0);
    send_item(16'h0005, 1'b1);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h0000, 1'b1);
    wait_drained();
    send_item(16'h0000, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'hFFFF, 1'b1);
    send_item(16'h0003, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h0003, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0002, 1'b0);
    send_item(16'h0001, 1'b1);
    wait_drained();

    // Full store of equal values hits the largest count; then last on a full
    // store; then a long overrun
    run_phase(11, 47, SHAPE_SAME, MAX_ELEMENTS);
    run_phase(47, 11, SHAPE_SPREAD, MAX_ELEMENTS + 1);
    run_phase(0, 0, SHAPE_FEW, MAX_ELEMENTS + 6);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
